### sv/wcdh_pkg.sv
package wcdh_pkg;

    localparam int C_POS_W   = 24;
    localparam int C_LEN_W   = 23;
    localparam int C_SLOT_W  = 12;
    localparam int C_TYPE_W  = 4;
    localparam int C_RBIN_W  = 8;
    localparam int C_LIM_W   = 9;
    localparam int C_CNT_W   = 32;
    localparam int C_MAG_W   = 24;
    localparam int C_SQ_W    = 48;
    localparam int C_RAD_W   = 50;
    localparam int C_ROOT_W  = C_RAD_W / 2;
    localparam int C_REM_W   = C_ROOT_W + 2;
    localparam int C_DIST_W  = C_ROOT_W - 8;
    localparam int C_DBIN_W  = 8;
    localparam int C_STEP_W  = $clog2(C_ROOT_W);
    localparam int C_ADDR_W  = 5;
    localparam int C_DATA_W  = 32;

    localparam int C_MAX_ATOMS = 4096;
    localparam int C_HIST_BINS = 256;

    localparam logic [C_LEN_W-1:0] C_RST_CUT    = 23'd256;
    localparam logic [C_LEN_W-1:0] C_RST_HEIGHT = 23'd25600;
    localparam logic [C_LEN_W-1:0] C_RST_LEN    = 23'd25600;
    localparam logic [C_TYPE_W-1:0] C_RST_TYPE  = 4'd1;
    localparam logic [C_LIM_W-1:0]  C_RST_LIMIT = 9'd200;

    typedef enum logic [2:0] {
        REG_CUT    = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_LEN_X  = 3'd2,
        REG_LEN_Y  = 3'd3,
        REG_TYPE   = 3'd4,
        REG_LIMIT  = 3'd5
    } t_reg;

    typedef struct packed {
        logic [C_LEN_W-1:0]  cut;
        logic [C_LEN_W-1:0]  height;
        logic [C_LEN_W-1:0]  len_x;
        logic [C_LEN_W-1:0]  len_y;
        logic [C_TYPE_W-1:0] ttype;
        logic [C_LIM_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic                       kind;
        logic [C_SLOT_W-1:0]        slot;
        logic [C_TYPE_W-1:0]        atype;
        logic signed [C_POS_W-1:0]  x;
        logic signed [C_POS_W-1:0]  y;
        logic signed [C_POS_W-1:0]  z;
        logic                       first;
        logic [C_RBIN_W-1:0]        rbin;
    } t_item;

    typedef struct packed {
        logic                       in_mid;
        logic                       open;
        logic signed [C_POS_W-1:0]  lx;
        logic signed [C_POS_W-1:0]  ly;
        logic signed [C_POS_W-1:0]  lz;
        logic signed [C_POS_W-1:0]  ex;
        logic signed [C_POS_W-1:0]  ey;
        logic signed [C_POS_W-1:0]  ez;
    } t_row;

    typedef struct packed {
        logic                       kind;
        logic [C_SLOT_W-1:0]        slot;
        logic                       top;
        logic [C_RBIN_W-1:0]        rbin;
        logic signed [C_POS_W-1:0]  x;
        logic signed [C_POS_W-1:0]  y;
        logic signed [C_POS_W-1:0]  ex;
        logic signed [C_POS_W-1:0]  ey;
    } t_job;

    typedef enum logic [1:0] {
        F_CLEAR,
        F_IDLE,
        F_WORK
    } t_fstate;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_LAT,
        B_SQ,
        B_SUM,
        B_ROOT,
        B_DIST,
        B_HWR,
        B_RRES
    } t_bstate;

    function automatic logic [C_MAG_W-1:0] lateral(
        input logic signed [C_POS_W-1:0] a,
        input logic signed [C_POS_W-1:0] b,
        input logic [C_LEN_W-1:0] len
    );
        logic signed [C_POS_W:0]   d;
        logic [C_POS_W:0]          ad;
        logic signed [C_POS_W+1:0] w;
        d  = (C_POS_W+1)'(a) - (C_POS_W+1)'(b);
        ad = d[C_POS_W] ? (C_POS_W+1)'(-d) : (C_POS_W+1)'(d);
        w  = $signed({1'b0, ad});
        if ({ad, 1'b0} > (C_POS_W+2)'(len)) begin
            w = $signed((C_POS_W+2)'(len)) - $signed({1'b0, ad});
        end
        if (w < 0) begin
            w = -w;
        end
        return C_MAG_W'(w);
    endfunction

endpackage

### sv/wcdh_ram.sv
module wcdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### sv/wcdh_fifo.sv
module wcdh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

### sv/wcdh_front.sv
module wcdh_front #(
    parameter int MAX_ATOMS = wcdh_pkg::C_MAX_ATOMS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wcdh_pkg::t_cfg   i_cfg,
    input  logic             i_take,
    input  wcdh_pkg::t_item  i_item,
    output logic             o_ready,
    input  logic             i_full,
    output logic             o_push,
    output wcdh_pkg::t_job   o_job
);

    localparam int AW = $clog2(MAX_ATOMS);

    wcdh_pkg::t_fstate r_state, n_state;
    wcdh_pkg::t_item   r_item;
    logic [AW-1:0]     r_clr, n_clr;
    wcdh_pkg::t_row    rd_row, wr_row;
    logic              we;
    logic [AW-1:0]     waddr;
    logic signed [wcdh_pkg::C_POS_W:0]   rc, hi, zz;
    logic signed [wcdh_pkg::C_POS_W+1:0] zsum;
    logic              band, tracked, need_push;

    wcdh_ram #(.WIDTH($bits(wcdh_pkg::t_row)), .DEPTH(MAX_ATOMS)) u_atoms (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_row),
        .i_re   (i_take),
        .i_raddr(AW'(i_item.slot)),
        .o_rdata(rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_state <= wcdh_pkg::F_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        rc   = $signed({2'b0, i_cfg.cut});
        hi   = $signed({2'b0, i_cfg.height}) - $signed({2'b0, i_cfg.cut});
        zz   = (wcdh_pkg::C_POS_W+1)'(r_item.z);
        band = (zz >= rc) && (zz <= hi);
        zsum = (wcdh_pkg::C_POS_W+2)'(rd_row.ez) + (wcdh_pkg::C_POS_W+2)'(r_item.z);
        tracked = (r_item.atype == i_cfg.ttype)
            && (32'(r_item.slot) < 32'(MAX_ATOMS));

        wr_row        = rd_row;
        wr_row.lx     = r_item.x;
        wr_row.ly     = r_item.y;
        wr_row.lz     = r_item.z;
        need_push     = 1'b0;
        if (r_item.kind) begin
            need_push = 1'b1;
        end else if (r_item.first) begin
            wr_row.in_mid = band;
        end else if (!band) begin
            if (rd_row.in_mid) begin
                wr_row.open = 1'b1;
                wr_row.ex   = rd_row.lx;
                wr_row.ey   = rd_row.ly;
                wr_row.ez   = rd_row.lz;
            end
            wr_row.in_mid = 1'b0;
        end else begin
            if (rd_row.open && tracked) begin
                need_push   = 1'b1;
                wr_row.open = 1'b0;
            end
            wr_row.in_mid = 1'b1;
        end

        o_job.kind = r_item.kind;
        o_job.slot = r_item.slot;
        o_job.top  = (zsum >= $signed({3'b0, i_cfg.height}));
        o_job.rbin = r_item.rbin;
        o_job.x    = r_item.x;
        o_job.y    = r_item.y;
        o_job.ex   = rd_row.ex;
        o_job.ey   = rd_row.ey;

        n_state = r_state;
        n_clr   = r_clr;
        we      = 1'b0;
        waddr   = AW'(r_item.slot);
        o_push  = 1'b0;
        o_ready = 1'b0;
        case (r_state)
            wcdh_pkg::F_CLEAR: begin
                // zero every row once after reset
                we     = 1'b1;
                waddr  = r_clr;
                wr_row = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == AW'(MAX_ATOMS-1)) begin
                    n_state = wcdh_pkg::F_IDLE;
                end
            end
            wcdh_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_take) begin
                    n_state = wcdh_pkg::F_WORK;
                end
            end
            wcdh_pkg::F_WORK: begin
                if (!(need_push && i_full)) begin
                    o_push  = need_push;
                    we      = !r_item.kind && tracked;
                    n_state = wcdh_pkg::F_IDLE;
                end
            end
            default: n_state = wcdh_pkg::F_IDLE;
        endcase
    end

endmodule

### sv/wcdh_back.sv
module wcdh_back #(
    parameter int HIST_BINS = wcdh_pkg::C_HIST_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcdh_pkg::t_cfg                i_cfg,
    input  logic                          i_empty,
    input  wcdh_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_result_kind,
    output logic [wcdh_pkg::C_SLOT_W-1:0] o_collided_slot,
    output logic                          o_left_top,
    output logic [wcdh_pkg::C_DBIN_W-1:0] o_displacement_bin,
    output logic                          o_counted,
    output logic [wcdh_pkg::C_CNT_W-1:0]  o_bin_count
);

    localparam int HW = $clog2(HIST_BINS);

    wcdh_pkg::t_bstate r_state, n_state;
    wcdh_pkg::t_job    r_job;
    logic [HW-1:0]     r_clr;
    logic [wcdh_pkg::C_MAG_W-1:0]  r_dx, r_dy;
    logic [wcdh_pkg::C_SQ_W-1:0]   r_sx, r_sy;
    logic [wcdh_pkg::C_RAD_W-1:0]  r_rad;
    logic [wcdh_pkg::C_REM_W-1:0]  r_rem, rem_sh, trial;
    logic [wcdh_pkg::C_ROOT_W-1:0] r_root;
    logic [wcdh_pkg::C_STEP_W-1:0] r_step;
    logic [wcdh_pkg::C_DIST_W-1:0] r_dist;
    logic              r_cnt_ok;
    logic [HW-1:0]     r_bin;
    logic              out_free;
    logic              we, re;
    logic [HW-1:0]     waddr, raddr;
    logic [wcdh_pkg::C_CNT_W-1:0] wdata, rdata;

    wcdh_ram #(.WIDTH(wcdh_pkg::C_CNT_W), .DEPTH(HIST_BINS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign out_free = !o_out_valid || !i_out_stall;
    assign rem_sh   = {r_rem[wcdh_pkg::C_REM_W-3:0],
                       r_rad[wcdh_pkg::C_RAD_W-1 -: 2]};
    assign trial    = {r_root, 2'b01};

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_ready = (r_state != wcdh_pkg::B_CLEAR);
        we      = 1'b0;
        waddr   = r_bin;
        wdata   = (rdata == '1) ? rdata : rdata + 1'b1;
        re      = 1'b0;
        raddr   = r_bin;
        case (r_state)
            wcdh_pkg::B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == HW'(HIST_BINS-1)) begin
                    n_state = wcdh_pkg::B_IDLE;
                end
            end
            wcdh_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.kind) begin
                        re      = 1'b1;
                        raddr   = HW'(i_job.rbin);
                        n_state = wcdh_pkg::B_RRES;
                    end else begin
                        n_state = wcdh_pkg::B_LAT;
                    end
                end
            end
            wcdh_pkg::B_LAT:  n_state = wcdh_pkg::B_SQ;
            wcdh_pkg::B_SQ:   n_state = wcdh_pkg::B_SUM;
            wcdh_pkg::B_SUM:  n_state = wcdh_pkg::B_ROOT;
            wcdh_pkg::B_ROOT: begin
                if (r_step == wcdh_pkg::C_STEP_W'(wcdh_pkg::C_ROOT_W-1)) begin
                    n_state = wcdh_pkg::B_DIST;
                end
            end
            wcdh_pkg::B_DIST: n_state = wcdh_pkg::B_HWR;
            wcdh_pkg::B_HWR: begin
                re = 1'b0;
                if (out_free) begin
                    we      = r_cnt_ok;
                    n_state = wcdh_pkg::B_IDLE;
                end
            end
            wcdh_pkg::B_RRES: begin
                if (out_free) begin
                    n_state = wcdh_pkg::B_IDLE;
                end
            end
            default: n_state = wcdh_pkg::B_IDLE;
        endcase
        if (r_state == wcdh_pkg::B_DIST) begin
            re    = 1'b1;
            raddr = (32'(r_dist) >= 32'(HIST_BINS)) ? HW'(HIST_BINS-1) : HW'(r_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            wcdh_pkg::B_LAT: begin
                r_dx <= wcdh_pkg::lateral(r_job.x, r_job.ex, i_cfg.len_x);
                r_dy <= wcdh_pkg::lateral(r_job.y, r_job.ey, i_cfg.len_y);
            end
            wcdh_pkg::B_SQ: begin
                r_sx <= r_dx * r_dx;
                r_sy <= r_dy * r_dy;
            end
            wcdh_pkg::B_SUM: begin
                r_rad  <= wcdh_pkg::C_RAD_W'(r_sx) + wcdh_pkg::C_RAD_W'(r_sy);
                r_rem  <= '0;
                r_root <= '0;
            end
            wcdh_pkg::B_ROOT: begin
                // two radicand bits per step
                r_rad <= {r_rad[wcdh_pkg::C_RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[wcdh_pkg::C_ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[wcdh_pkg::C_ROOT_W-2:0], 1'b0};
                end
            end
            wcdh_pkg::B_DIST: begin
                r_cnt_ok <= (32'(r_dist) < 32'(i_cfg.limit));
                r_bin    <= (32'(r_dist) >= 32'(HIST_BINS)) ? HW'(HIST_BINS-1) : HW'(r_dist);
            end
            default: ;
        endcase
        if (r_state == wcdh_pkg::B_ROOT
                && r_step == wcdh_pkg::C_STEP_W'(wcdh_pkg::C_ROOT_W-1)) begin
            r_dist <= (rem_sh >= trial) ? r_root[wcdh_pkg::C_ROOT_W-2 -: wcdh_pkg::C_DIST_W]
                                        : r_root[wcdh_pkg::C_ROOT_W-2 -: wcdh_pkg::C_DIST_W];
        end
        if (r_state == wcdh_pkg::B_HWR && out_free) begin
            o_result_kind      <= 1'b0;
            o_collided_slot    <= r_job.slot;
            o_left_top         <= r_job.top;
            o_displacement_bin <= (r_dist > wcdh_pkg::C_DIST_W'(255)) ? 8'hFF
                                  : r_dist[wcdh_pkg::C_DBIN_W-1:0];
            o_counted          <= r_cnt_ok;
            o_bin_count        <= '0;
        end else if (r_state == wcdh_pkg::B_RRES && out_free) begin
            o_result_kind      <= 1'b1;
            o_collided_slot    <= '0;
            o_left_top         <= 1'b0;
            o_displacement_bin <= '0;
            o_counted          <= 1'b0;
            o_bin_count        <= (32'(r_job.rbin) < 32'(HIST_BINS)) ? rdata : '0;
        end
        if (!i_rst_n) begin
            r_state     <= wcdh_pkg::B_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wcdh_pkg::B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_step <= (r_state == wcdh_pkg::B_ROOT) ? r_step + 1'b1 : '0;
            if ((r_state == wcdh_pkg::B_HWR || r_state == wcdh_pkg::B_RRES) && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/wall_collision_displacement_histogram.sv
// wall collision displacement histogram
// input channel: i_in_valid / o_in_stall, one item per transfer, either an
//   atom sample (kind 0) or a histogram bin read (kind 1)
// output channel: o_out_valid / i_out_stall, one result per transfer: a
//   collision record when a tracked atom re-enters the middle band, or the
//   count of the requested bin for a read
// config: apb writes at byte address 4*index, reads return the register
// front part: one per-atom row read and write back per item, one item at a time
// back part: steps per collision record (pop, lateral diff, squares, sum,
//   25-step bit-serial square root, bin select, histogram read-modify-write),
//   a read returns its bin count; a 4-entry job queue sits between the parts
// samples that produce no result pass through the front part only
// reset: the per-atom table (MAX_ATOMS rows) and the histogram (HIST_BINS
//   bins) are swept to zero; o_in_stall stays high until both are done
// a stalled output holds its result; the back part waits and the queue
//   then the front fill up before the input stalls
module wall_collision_displacement_histogram #(
    parameter int MAX_ATOMS = wcdh_pkg::C_MAX_ATOMS,
    parameter int HIST_BINS = wcdh_pkg::C_HIST_BINS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcdh_pkg::C_ADDR_W-1:0]  paddr,
    input  logic [wcdh_pkg::C_DATA_W-1:0]  pwdata,
    output logic [wcdh_pkg::C_DATA_W-1:0]  prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [wcdh_pkg::C_SLOT_W-1:0]  i_atom_slot,
    input  logic [wcdh_pkg::C_TYPE_W-1:0]  i_atom_type,
    input  logic signed [wcdh_pkg::C_POS_W-1:0] i_pos_x,
    input  logic signed [wcdh_pkg::C_POS_W-1:0] i_pos_y,
    input  logic signed [wcdh_pkg::C_POS_W-1:0] i_pos_z,
    input  logic                           i_first_frame,
    input  logic [wcdh_pkg::C_RBIN_W-1:0]  i_read_bin,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_result_kind,
    output logic [wcdh_pkg::C_SLOT_W-1:0]  o_collided_slot,
    output logic                           o_left_top,
    output logic [wcdh_pkg::C_DBIN_W-1:0]  o_displacement_bin,
    output logic                           o_counted,
    output logic [wcdh_pkg::C_CNT_W-1:0]   o_bin_count
);

    wcdh_pkg::t_cfg  r_cfg;
    wcdh_pkg::t_item item;
    wcdh_pkg::t_job  push_job, pop_job;
    wcdh_pkg::t_reg  reg_idx;
    logic            take, front_ready, back_ready;
    logic            push, pop, full, empty;

    assign pready  = 1'b1;
    assign reg_idx = wcdh_pkg::t_reg'(paddr[wcdh_pkg::C_ADDR_W-1:2]);

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cut    <= wcdh_pkg::C_RST_CUT;
            r_cfg.height <= wcdh_pkg::C_RST_HEIGHT;
            r_cfg.len_x  <= wcdh_pkg::C_RST_LEN;
            r_cfg.len_y  <= wcdh_pkg::C_RST_LEN;
            r_cfg.ttype  <= wcdh_pkg::C_RST_TYPE;
            r_cfg.limit  <= wcdh_pkg::C_RST_LIMIT;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                wcdh_pkg::REG_CUT:    r_cfg.cut    <= pwdata[wcdh_pkg::C_LEN_W-1:0];
                wcdh_pkg::REG_HEIGHT: r_cfg.height <= pwdata[wcdh_pkg::C_LEN_W-1:0];
                wcdh_pkg::REG_LEN_X:  r_cfg.len_x  <= pwdata[wcdh_pkg::C_LEN_W-1:0];
                wcdh_pkg::REG_LEN_Y:  r_cfg.len_y  <= pwdata[wcdh_pkg::C_LEN_W-1:0];
                wcdh_pkg::REG_TYPE:   r_cfg.ttype  <= pwdata[wcdh_pkg::C_TYPE_W-1:0];
                wcdh_pkg::REG_LIMIT:  r_cfg.limit  <= pwdata[wcdh_pkg::C_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wcdh_pkg::REG_CUT:    prdata = 32'(r_cfg.cut);
            wcdh_pkg::REG_HEIGHT: prdata = 32'(r_cfg.height);
            wcdh_pkg::REG_LEN_X:  prdata = 32'(r_cfg.len_x);
            wcdh_pkg::REG_LEN_Y:  prdata = 32'(r_cfg.len_y);
            wcdh_pkg::REG_TYPE:   prdata = 32'(r_cfg.ttype);
            wcdh_pkg::REG_LIMIT:  prdata = 32'(r_cfg.limit);
            default:              prdata = '0;
        endcase
    end

    // input transfer
    assign o_in_stall = !(front_ready && back_ready);
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        item.kind  = i_kind;
        item.slot  = i_atom_slot;
        item.atype = i_atom_type;
        item.x     = i_pos_x;
        item.y     = i_pos_y;
        item.z     = i_pos_z;
        item.first = i_first_frame;
        item.rbin  = i_read_bin;
    end

    wcdh_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_take (take),
        .i_item (item),
        .o_ready(front_ready),
        .i_full (full),
        .o_push (push),
        .o_job  (push_job)
    );

    // job queue between classification and the arithmetic
    wcdh_fifo #(.WIDTH($bits(wcdh_pkg::t_job)), .DEPTH(4)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_job),
        .i_pop  (pop),
        .o_data (pop_job),
        .o_full (full),
        .o_empty(empty)
    );

    wcdh_back #(.HIST_BINS(HIST_BINS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (empty),
        .i_job             (pop_job),
        .o_pop             (pop),
        .o_ready           (back_ready),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_collided_slot   (o_collided_slot),
        .o_left_top        (o_left_top),
        .o_displacement_bin(o_displacement_bin),
        .o_counted         (o_counted),
        .o_bin_count       (o_bin_count)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full) else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("job popped from an empty queue");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_in_stall) else $error("front took a second item back to back");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> back_ready && front_ready) else $error("item taken during clear");

endmodule
